/* design/bsc_pkg.sv */
// Shared types and constants of the barometric compensation unit.
// No dependencies.
package bsc_pkg;

	localparam int unsigned RegCount = 8;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_AC1 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_AC2 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_AC3 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_AC4 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TSO = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_B1 = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_B2 = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_TCP = 3'd7;

	localparam logic OP_TEMP = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	typedef enum logic [4:0] {
		S_NOP,
		T_X1, T_DEN, T_DIV, T_FIN,
		P_UP, P_SQ, P_X1, P_X2, P_B3, P_A3, P_B1, P_X3, P_B4, P_B7,
		P_DIV, P_P, P_SQP, P_K1, P_K2, P_FIN
	} step_t;

	typedef struct packed {
		logic load;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic b4_zero;
		logic div_done;
	} stat_t;

endpackage

/* design/barometric_sensor_compensation_unit.sv */
// Top level of the barometric compensation unit: sequencer plus datapath.
// Depends on bsc_pkg, bsc_ctrl, bsc_datapath, bsc_divider.
// One item at a time: in_ready stays low from accept until the result beat is
// taken, so a new beat is accepted only after the last result has left. Most of
// the work is the 32-step serial divider. A zero divisor ends the item early
// with the fault flag. Reset restores the coefficient defaults and clears the
// stored temperature term.
module barometric_sensor_compensation_unit import bsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [23:0]        raw_reading,
	input  logic [1:0]         oversampling,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               reading_kind,
	output logic signed [31:0] value,
	output logic               divide_fault,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data
);
	cmd_t  cmd;
	stat_t stat;

	// always take coefficient writes; they are registered and take effect in the cycle after
	assign cfg_ready = 1'b1;

	// sequence the steps; hold the result until the beat is taken
	bsc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	// shared multiplier, divider and work registers
	bsc_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_we(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.op(op),
		.raw_reading(raw_reading),
		.oversampling(oversampling),
		.reading_kind(reading_kind),
		.value(value),
		.divide_fault(divide_fault)
	);
endmodule

/* design/bsc_divider.sv */
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// Depends on nothing.
module bsc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

/* design/bsc_datapath.sv */
// Datapath: coefficient registers, work registers, shared multiplier, divider.
// Depends on bsc_pkg and bsc_divider.
module bsc_datapath import bsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               op,
	input  logic [23:0]        raw_reading,
	input  logic [1:0]         oversampling,
	output logic               reading_kind,
	output logic signed [31:0] value,
	output logic               divide_fault
);
	logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, b1_q, b2_q;
	logic [31:0] tso_q, tcp_q;
	logic [31:0] temp_term_q;

	logic        op_q;
	logic [23:0] raw_q;
	logic [1:0]  oss_q;

	logic [31:0] x1_q, den_q, num_q, b6_q, up_q, sq_q, a_q, x_q, b3_q, b4_q, b7_q, p_q;
	logic        neg_q;
	logic [31:0] value_q;
	logic        fault_q;

	logic [31:0] mul_a, mul_b, prod;
	logic        div_start;
	logic [31:0] div_dnd, div_dsr, div_quo;
	logic        div_done;

	logic [31:0] p_shr8, b3_sum, b3_val, q_signed, tt_new, den_mag, num_mag, b4_arg;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_q <= 16'd408;
			ac2_q <= 16'hFFB8;
			ac3_q <= 16'hC7D1;
			ac4_q <= 16'd32741;
			tso_q <= 32'd2146785905;
			b1_q <= 16'd6190;
			b2_q <= 16'd4;
			tcp_q <= 32'd3724086068;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1: ac1_q <= cfg_data[15:0];
				REG_AC2: ac2_q <= cfg_data[15:0];
				REG_AC3: ac3_q <= cfg_data[15:0];
				REG_AC4: ac4_q <= cfg_data[15:0];
				REG_TSO: tso_q <= cfg_data;
				REG_B1:  b1_q <= cfg_data[15:0];
				REG_B2:  b2_q <= cfg_data[15:0];
				REG_TCP: tcp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign p_shr8 = 32'($signed(p_q) >>> 8);
	assign b4_arg = x_q + 32'd32768;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			T_X1: begin
				mul_a = {16'd0, raw_q[15:0]} - {16'd0, tso_q[15:0]};
				mul_b = {16'd0, tso_q[31:16]};
			end
			P_SQ: begin mul_a = b6_q; mul_b = b6_q; end
			P_X1: begin mul_a = sx16(b2_q); mul_b = sq_q; end
			P_X2: begin mul_a = sx16(ac2_q); mul_b = b6_q; end
			P_A3: begin mul_a = sx16(ac3_q); mul_b = b6_q; end
			P_B1: begin mul_a = sx16(b1_q); mul_b = sq_q; end
			P_B4: begin mul_a = {16'd0, ac4_q}; mul_b = b4_arg; end
			P_B7: begin mul_a = up_q - b3_q; mul_b = 32'd50000 >> oss_q; end
			P_SQP: begin mul_a = p_shr8; mul_b = p_shr8; end
			P_K1: begin mul_a = a_q; mul_b = 32'd3038; end
			P_K2: begin mul_a = 32'd0 - 32'd7357; mul_b = p_q; end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// divide by four, truncating toward zero, of the shifted offset sum plus two
	assign b3_sum = ((sx16(ac1_q) << 2) + a_q + x_q) << oss_q;
	always_comb begin
		logic [31:0] v;
		v = b3_sum + 32'd2;
		b3_val = v[31] ? 32'd0 - ((32'd0 - v) >> 2) : v >> 2;
	end

	assign den_mag = den_q[31] ? 32'd0 - den_q : den_q;
	assign num_mag = num_q[31] ? 32'd0 - num_q : num_q;
	assign q_signed = neg_q ? 32'd0 - div_quo : div_quo;
	assign tt_new = x1_q + q_signed;

	always_comb begin
		div_start = 1'b0;
		div_dnd = num_mag;
		div_dsr = den_mag;
		if (cmd.step == T_DIV) begin
			div_start = (den_q != 32'd0);
		end else if (cmd.step == P_DIV) begin
			div_start = (b4_q != 32'd0);
			div_dnd = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
			div_dsr = b4_q;
		end
	end

	bsc_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dnd),
		.divisor(div_dsr),
		.done(div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_term_q <= '0;
		end else if (cmd.step == T_FIN) begin
			temp_term_q <= tt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			raw_q <= raw_reading;
			oss_q <= oversampling;
		end
		case (cmd.step)
			T_X1: x1_q <= 32'($signed(prod) >>> 15);
			T_DEN: begin
				den_q <= x1_q + sx16(tcp_q[15:0]);
				num_q <= sx16(tcp_q[31:16]) << 11;
			end
			T_DIV: begin
				neg_q <= num_q[31] ^ den_q[31];
				value_q <= '0;
				fault_q <= 1'b1;
			end
			T_FIN: begin
				value_q <= 32'($signed(tt_new + 32'd8) >>> 4);
				fault_q <= 1'b0;
			end
			P_UP: begin
				up_q <= {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
				b6_q <= temp_term_q - 32'd4000;
			end
			P_SQ: sq_q <= 32'($signed(prod) >>> 12);
			P_X1: a_q <= 32'($signed(prod) >>> 11);
			P_X2: x_q <= 32'($signed(prod) >>> 11);
			P_B3: b3_q <= b3_val;
			P_A3: a_q <= 32'($signed(prod) >>> 13);
			P_B1: x_q <= 32'($signed(prod) >>> 16);
			P_X3: x_q <= 32'($signed(a_q + x_q + 32'd2) >>> 2);
			P_B4: b4_q <= prod >> 15;
			P_B7: b7_q <= prod;
			P_DIV: begin
				neg_q <= b7_q[31];
				value_q <= '0;
				fault_q <= 1'b1;
			end
			P_P: p_q <= neg_q ? {div_quo[30:0], 1'b0} : div_quo;
			P_SQP: a_q <= prod;
			P_K1: a_q <= 32'($signed(prod) >>> 16);
			P_K2: x_q <= 32'($signed(prod) >>> 16);
			P_FIN: begin
				value_q <= p_q + 32'($signed(a_q + x_q + 32'd3791) >>> 4);
				fault_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign stat.den_zero = (den_q == 32'd0);
	assign stat.b4_zero = (b4_q == 32'd0);
	assign stat.div_done = div_done;

	assign reading_kind = op_q;
	assign value = value_q;
	assign divide_fault = fault_q;
endmodule

/* design/bsc_ctrl.sv */
// Sequencer that steps the datapath through one compensation.
// Depends on bsc_pkg.
module bsc_ctrl import bsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  op,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_OUT} state_t;

	state_t state_q;
	step_t  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= S_NOP;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_EXEC;
					step_q <= (op == OP_PRESS) ? P_UP : T_X1;
				end
				ST_EXEC: begin
					if (step_q == T_DIV) begin
						state_q <= stat.den_zero ? ST_OUT : ST_DIV;
					end else if (step_q == P_DIV) begin
						state_q <= stat.b4_zero ? ST_OUT : ST_DIV;
					end else if (step_q == T_FIN || step_q == P_FIN) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_t'(step_q + 5'd1);
					end
				end
				ST_DIV: if (stat.div_done) begin
					state_q <= ST_EXEC;
					step_q <= (step_q == T_DIV) ? T_FIN : P_P;
				end
				ST_OUT: if (out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.step = (state_q == ST_EXEC) ? step_q : S_NOP;
endmodule
